@@ rtl/mlc_pkg.sv @@
// ----------------------------------------------------------------------------
// mlc_pkg
// Types, constants and outcode helper shared by the midpoint line clipper.
// ----------------------------------------------------------------------------
package mlc_pkg;

   localparam int COORD_BITS = 16;
   localparam int BISECT_STEPS = COORD_BITS + 1;
   localparam int PASS_COUNT = 4;
   localparam int PASS_STAGES = BISECT_STEPS + 1;
   localparam int PIPE_STAGES = PASS_COUNT * PASS_STAGES + 1;
   localparam int ADDR_BITS = 4;
   localparam int DATA_BITS = 32;

   localparam logic [3:0] CODE_LEFT   = 4'h1;
   localparam logic [3:0] CODE_RIGHT  = 4'h2;
   localparam logic [3:0] CODE_BOTTOM = 4'h4;
   localparam logic [3:0] CODE_TOP    = 4'h8;

   localparam logic [1:0] REG_WIN_LEFT   = 2'd0;
   localparam logic [1:0] REG_WIN_BOTTOM = 2'd1;
   localparam logic [1:0] REG_WIN_RIGHT  = 2'd2;
   localparam logic [1:0] REG_WIN_TOP    = 2'd3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0] wide_type;

   typedef struct packed {
      coord_type left;
      coord_type bottom;
      coord_type right;
      coord_type top;
   } win_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic      visible;
      coord_type clip_start_x;
      coord_type clip_start_y;
      coord_type clip_end_x;
      coord_type clip_end_y;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic       done;
      logic       vis;
      logic       cur;
      logic       clip;
      coord_type  x0;
      coord_type  y0;
      coord_type  x1;
      coord_type  y1;
      coord_type  ax;
      coord_type  ay;
      coord_type  bx;
      coord_type  by;
      logic [3:0] acode;
   } pipe_type;

   function automatic logic [3:0] outcode(coord_type x, coord_type y, win_type w);
      logic [3:0] c;
      c = 4'h0;
      if (x < w.left) begin
         c = c | CODE_LEFT;
      end else if (x > w.right) begin
         c = c | CODE_RIGHT;
      end
      if (y < w.bottom) begin
         c = c | CODE_BOTTOM;
      end else if (y > w.top) begin
         c = c | CODE_TOP;
      end
      return c;
   endfunction

endpackage

@@ rtl/mlc_check.sv @@
// ----------------------------------------------------------------------------
// mlc_check
// Pass boundary stage: writes back the clipped end, classifies the segment
// and picks the outside end for the next bisection run, or rejects if FINAL.
// ----------------------------------------------------------------------------
module mlc_check #(
   parameter bit FINAL = 1'b0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  mlc_pkg::win_type  win,
   input  mlc_pkg::pipe_type in_data,
   output mlc_pkg::pipe_type out_data
);
   import mlc_pkg::*;

   pipe_type   out_ff;
   pipe_type   out_in;
   pipe_type   wb;
   logic [3:0] c0;
   logic [3:0] c1;
   logic       cur_n;

   always_comb begin
      wb = in_data;
      if (in_data.clip) begin
         if (in_data.cur) begin
            wb.x1 = in_data.bx;
            wb.y1 = in_data.by;
         end else begin
            wb.x0 = in_data.bx;
            wb.y0 = in_data.by;
         end
      end
      c0 = outcode(wb.x0, wb.y0, win);
      c1 = outcode(wb.x1, wb.y1, win);
      cur_n = in_data.cur;
      if ((in_data.cur ? c1 : c0) == 4'h0) begin
         cur_n = ~in_data.cur;
      end
      out_in = wb;
      out_in.clip = 1'b0;
      if (!in_data.done) begin
         if ((c0 | c1) == 4'h0) begin
            out_in.done = 1'b1;
            out_in.vis = 1'b1;
         end else if (((c0 & c1) != 4'h0) || FINAL) begin
            out_in.done = 1'b1;
            out_in.vis = 1'b0;
         end else begin
            out_in.cur = cur_n;
            out_in.clip = 1'b1;
            out_in.ax = cur_n ? wb.x1 : wb.x0;
            out_in.ay = cur_n ? wb.y1 : wb.y0;
            out_in.bx = cur_n ? wb.x0 : wb.x1;
            out_in.by = cur_n ? wb.y0 : wb.y1;
            out_in.acode = cur_n ? c1 : c0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_data = out_ff;

`ifndef SYNTHESIS
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      en && in_data.valid && in_data.done |=> out_ff.done && !out_ff.clip)
      else $error("finished transaction reopened");
   a_clip_outside: assert property (@(posedge clock) disable iff (reset)
      en && in_data.valid |=> !out_ff.clip || (out_ff.acode != 4'h0))
      else $error("bisection started from an inside end");
   a_final_done: assert property (@(posedge clock) disable iff (reset)
      en && in_data.valid && FINAL |=> out_ff.done)
      else $error("transaction left the last pass unsettled");
`endif

endmodule

@@ rtl/mlc_bisect.sv @@
// ----------------------------------------------------------------------------
// mlc_bisect
// One midpoint bisection step between the outside end a and the end b.
// ----------------------------------------------------------------------------
module mlc_bisect (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  mlc_pkg::win_type  win,
   input  mlc_pkg::pipe_type in_data,
   output mlc_pkg::pipe_type out_data
);
   import mlc_pkg::*;

   pipe_type   out_ff;
   pipe_type   out_in;
   wide_type   dx;
   wide_type   dy;
   wide_type   sx;
   wide_type   sy;
   coord_type  mx;
   coord_type  my;
   logic [3:0] mcode;
   logic       conv;

   always_comb begin
      dx = wide_type'(in_data.ax) - wide_type'(in_data.bx);
      dy = wide_type'(in_data.ay) - wide_type'(in_data.by);
      conv = ((dx == wide_type'(0)) || (dx == wide_type'(1)) || (dx == wide_type'(-1)))
          && ((dy == wide_type'(0)) || (dy == wide_type'(1)) || (dy == wide_type'(-1)));
      sx = wide_type'(in_data.ax) + wide_type'(in_data.bx);
      sy = wide_type'(in_data.ay) + wide_type'(in_data.by);
      mx = sx[COORD_BITS:1];
      my = sy[COORD_BITS:1];
      mcode = outcode(mx, my, win);
      out_in = in_data;
      if (in_data.clip && !conv) begin
         if ((in_data.acode & mcode) != 4'h0) begin
            out_in.ax = mx;
            out_in.ay = my;
            out_in.acode = mcode;
         end else begin
            out_in.bx = mx;
            out_in.by = my;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_data = out_ff;

`ifndef SYNTHESIS
   a_a_outside: assert property (@(posedge clock) disable iff (reset)
      en && in_data.valid && in_data.clip && (in_data.acode != 4'h0)
      |=> out_ff.acode != 4'h0)
      else $error("outside end moved inside");
   a_conv_hold: assert property (@(posedge clock) disable iff (reset)
      en && in_data.valid && conv
      |=> out_ff.ax == $past(in_data.ax) && out_ff.bx == $past(in_data.bx))
      else $error("converged pair changed");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en && out_ff.valid |=> $stable(out_ff))
      else $error("stage changed while stalled");
`endif

endmodule

@@ rtl/midpoint_line_clipper_unit.sv @@
// ----------------------------------------------------------------------------
// midpoint_line_clipper_unit
// Clips line segments against a rectangular window by midpoint bisection.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one segment per transaction (start and end point).
//   rsp channel returns one transaction per segment: visible flag and the
//   clipped endpoints, all zero when the segment is rejected.
//   csr port holds the window: left at 0x0, bottom at 0x4, right at 0x8,
//   top at 0xc; write only while no transaction is in flight.
// Four passes, each one classify stage and 17 bisection stages, plus
// a final classify stage. Throughput is one segment per cycle while rsp
// is not stalled; every stage is a register with a valid bit.
// Reset empties the pipeline and loads the window -300..300 by -100..100.
// A stall on rsp while a result is valid freezes the whole pipeline and
// raises req_stall in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module midpoint_line_clipper_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mlc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mlc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mlc_pkg::ADDR_BITS-1:0]      csr_paddr,
   input  logic [mlc_pkg::DATA_BITS-1:0]      csr_pwdata,
   output logic [mlc_pkg::DATA_BITS-1:0]      csr_prdata,
   output logic                               csr_pready
);
   import mlc_pkg::*;

   win_type  win_ff;
   pipe_type stg [0:PIPE_STAGES];
   pipe_type last;
   logic     en;
   logic     wr;
   coord_type rd;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.left   <= coord_type'(-300);
         win_ff.bottom <= coord_type'(-100);
         win_ff.right  <= coord_type'(300);
         win_ff.top    <= coord_type'(100);
      end else if (wr) begin
         unique case (csr_paddr[3:2])
            REG_WIN_LEFT:   win_ff.left   <= csr_pwdata[COORD_BITS-1:0];
            REG_WIN_BOTTOM: win_ff.bottom <= csr_pwdata[COORD_BITS-1:0];
            REG_WIN_RIGHT:  win_ff.right  <= csr_pwdata[COORD_BITS-1:0];
            REG_WIN_TOP:    win_ff.top    <= csr_pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_WIN_LEFT:   rd = win_ff.left;
         REG_WIN_BOTTOM: rd = win_ff.bottom;
         REG_WIN_RIGHT:  rd = win_ff.right;
         REG_WIN_TOP:    rd = win_ff.top;
         default:        rd = win_ff.left;
      endcase
      csr_prdata = DATA_BITS'(rd);
   end

   assign last = stg[PIPE_STAGES];
   assign en = !(last.valid && rsp_stall);
   assign req_stall = last.valid && rsp_stall;

   always_comb begin
      stg[0] = '0;
      stg[0].valid = req_valid;
      stg[0].x0 = req_data.start_x;
      stg[0].y0 = req_data.start_y;
      stg[0].x1 = req_data.end_x;
      stg[0].y1 = req_data.end_y;
   end

   genvar gp;
   genvar gb;
   generate
      for (gp = 0; gp < PASS_COUNT; gp++) begin : g_pass
         mlc_check #(.FINAL(1'b0)) u_check (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .win      (win_ff),
            .in_data  (stg[gp*PASS_STAGES]),
            .out_data (stg[gp*PASS_STAGES+1])
         );
         for (gb = 0; gb < BISECT_STEPS; gb++) begin : g_step
            mlc_bisect u_bisect (
               .clock    (clock),
               .reset    (reset),
               .en       (en),
               .win      (win_ff),
               .in_data  (stg[gp*PASS_STAGES+1+gb]),
               .out_data (stg[gp*PASS_STAGES+2+gb])
            );
         end
      end
   endgenerate

   mlc_check #(.FINAL(1'b1)) u_check_final (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .win      (win_ff),
      .in_data  (stg[PIPE_STAGES-1]),
      .out_data (stg[PIPE_STAGES])
   );

   always_comb begin
      rsp_valid = last.valid;
      rsp_data = '0;
      if (last.vis) begin
         rsp_data.visible = 1'b1;
         rsp_data.clip_start_x = last.x0;
         rsp_data.clip_start_y = last.y0;
         rsp_data.clip_end_x = last.x1;
         rsp_data.clip_end_y = last.y1;
      end
   end

`ifndef SYNTHESIS
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output stalled");
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last.vis |-> rsp_data == '0)
      else $error("rejected transaction carries coordinates");
   a_last_settled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> last.done)
      else $error("unsettled transaction at output");
`endif

endmodule
